// File: src/two_axis_step_dir_positioner_unit_defines.svh
// assertion helpers used by the positioner top level
`ifndef TWO_AXIS_STEP_DIR_POSITIONER_UNIT_DEFINES_SVH
`define TWO_AXIS_STEP_DIR_POSITIONER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TDSDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TDSDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tdsdp_pkg.sv
package tdsdp_pkg;

    localparam int P_POS_BITS   = 16;
    localparam int P_GOAL_BITS  = 16;
    localparam int P_OUT_BITS   = 16;
    localparam int P_RATE_BITS  = 7;
    localparam int P_PHASE_BITS = 7;
    localparam int P_PROD_BITS  = 14;
    localparam int P_RECIP_BITS = 27;

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 12800
    localparam logic [12:0] P_RECIP_100 = 13'd5243;
    localparam int          P_RECIP_SHIFT = 19;

    localparam logic [P_PHASE_BITS-1:0] P_PHASE_LAST = 7'd99;
    localparam logic [7:0]              P_PINS_RESET = 8'h04;

    localparam int P_PIN_X_DIR  = 0;
    localparam int P_PIN_X_STEP = 1;
    localparam int P_PIN_Y_DIR  = 4;
    localparam int P_PIN_Y_STEP = 5;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_HOME = 2'd1;
    localparam logic [1:0] ACT_MOVE = 2'd2;

    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_HOME = 2'd1;
    localparam logic [1:0] MODE_CODE_MOVE = 2'd2;

    localparam logic REG_X_RATE = 1'b0;
    localparam logic REG_Y_RATE = 1'b1;

    typedef logic [P_POS_BITS-1:0] t_pos;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_HOMING = 3'b010,
        MODE_MOVE   = 3'b100
    } t_mode;

    typedef struct packed {
        logic [1:0]                    action;
        logic signed [P_GOAL_BITS-1:0] goal_x;
        logic signed [P_GOAL_BITS-1:0] goal_y;
        logic                          x_switch_n;
        logic                          y_switch_n;
    } t_item;

    typedef struct packed {
        logic [7:0]                   port_pins;
        logic signed [P_OUT_BITS-1:0] x_position;
        logic signed [P_OUT_BITS-1:0] y_position;
        logic                         x_limit_hit;
        logic                         y_limit_hit;
        logic                         homed_pulse;
        logic                         motion_active;
        logic [1:0]                   current_mode;
    } t_result;

    function automatic logic [P_RATE_BITS-1:0] div100(input logic [P_PROD_BITS-1:0] x);
        logic [P_RECIP_BITS-1:0] prod;
        prod = P_RECIP_BITS'(x) * P_RECIP_BITS'(P_RECIP_100);
        return prod[P_RECIP_SHIFT +: P_RATE_BITS];
    endfunction

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] code;
        case (m)
            MODE_HOMING: code = MODE_CODE_HOME;
            MODE_MOVE:   code = MODE_CODE_MOVE;
            default:     code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: src/two_axis_step_dir_positioner_unit.sv
// two-axis step/direction positioner. every item is one tick or one command
// (start homing, or load goals and move) and gives exactly one result item
// with the pin byte, both positions, limit flags, homed pulse, motion flag and
// mode. throughput is one item per clock while the result side is not stalled;
// an item is held in the input register and then in the result register. the
// rate is set by the combinational update of the axis state (goal compares,
// limit check, rate test and position increment) in the control unit. the rate
// registers may only be written while no item is in flight. the output register
// and the input register decouple the two handshakes, so a new item is taken
// while a result is still waiting.
`include "two_axis_step_dir_positioner_unit_defines.svh"

module two_axis_step_dir_positioner_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // item in
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [1:0]                               i_action,
    input  logic signed [tdsdp_pkg::P_GOAL_BITS-1:0] i_goal_x,
    input  logic signed [tdsdp_pkg::P_GOAL_BITS-1:0] i_goal_y,
    input  logic                                     i_x_switch_n,
    input  logic                                     i_y_switch_n,
    // result out
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [7:0]                               o_port_pins,
    output logic signed [tdsdp_pkg::P_OUT_BITS-1:0]  o_x_position,
    output logic signed [tdsdp_pkg::P_OUT_BITS-1:0]  o_y_position,
    output logic                                     o_x_limit_hit,
    output logic                                     o_y_limit_hit,
    output logic                                     o_homed_pulse,
    output logic                                     o_motion_active,
    output logic [1:0]                               o_current_mode,
    // rate register writes
    input  logic                                     i_cfg_we,
    input  logic                                     i_cfg_idx,
    input  logic [tdsdp_pkg::P_RATE_BITS-1:0]        i_cfg_data
);
    import tdsdp_pkg::*;

    // input register
    logic  r_in_vld;
    t_item r_in;

    // rate registers, toggles per hundred ticks
    logic [P_RATE_BITS-1:0] r_x_rate;
    logic [P_RATE_BITS-1:0] r_y_rate;

    logic    w_take;
    logic    w_accept;
    t_result w_res;

    // the input register frees as the control unit takes its item
    assign o_ready  = !r_in_vld || w_take;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_take) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.action     <= i_action;
            r_in.goal_x     <= i_goal_x;
            r_in.goal_y     <= i_goal_y;
            r_in.x_switch_n <= i_x_switch_n;
            r_in.y_switch_n <= i_y_switch_n;
        end
    end

    // configuration writes, no handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_rate <= '0;
            r_y_rate <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_RATE: r_x_rate <= i_cfg_data;
                REG_Y_RATE: r_y_rate <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // mode, axis state, step timing and the result register
    tdsdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (r_in_vld),
        .i_item      (r_in),
        .i_x_rate    (r_x_rate),
        .i_y_rate    (r_y_rate),
        .i_out_ready (i_ready),
        .o_take      (w_take),
        .o_res_vld   (o_valid),
        .o_res       (w_res)
    );

    assign o_port_pins     = w_res.port_pins;
    assign o_x_position    = w_res.x_position;
    assign o_y_position    = w_res.y_position;
    assign o_x_limit_hit   = w_res.x_limit_hit;
    assign o_y_limit_hit   = w_res.y_limit_hit;
    assign o_homed_pulse   = w_res.homed_pulse;
    assign o_motion_active = w_res.motion_active;
    assign o_current_mode  = w_res.current_mode;

    // homing finishes by entering move mode with both counts cleared
    `TDSDP_ASSERT_NOW(a_homed_mode, o_valid && o_homed_pulse,
        o_current_mode == MODE_CODE_MOVE && o_x_position == '0 && o_y_position == '0,
        "homed item not in move mode with zero positions")
    // a limit is only flagged while the axis points negative
    `TDSDP_ASSERT_NOW(a_limit_dir, o_valid && (o_x_limit_hit || o_y_limit_hit),
        (!o_x_limit_hit || !o_port_pins[P_PIN_X_DIR])
            && (!o_y_limit_hit || !o_port_pins[P_PIN_Y_DIR]),
        "limit flagged on an axis moving positive")
    // idle never reports motion
    `TDSDP_ASSERT_NOW(a_idle_still, o_valid && o_current_mode == MODE_CODE_IDLE,
        !o_motion_active, "idle mode with motion reported")
    // an item taken from the input register always shows up as a result
    `TDSDP_ASSERT_NEXT(a_take_result, w_take, o_valid,
        "item taken without a result")

endmodule

// File: src/tdsdp_rate.sv
module tdsdp_rate (
    input  logic [tdsdp_pkg::P_RATE_BITS-1:0]  i_rate,
    input  logic [tdsdp_pkg::P_PHASE_BITS-1:0] i_phase,
    output logic                               o_edge
);
    import tdsdp_pkg::*;

    logic [P_PROD_BITS-1:0] w_prod_now;
    logic [P_PROD_BITS-1:0] w_prod_next;

    // edge when floor(rate*phase/100) moves on between this phase and the next
    assign w_prod_now  = P_PROD_BITS'(i_rate) * P_PROD_BITS'(i_phase);
    assign w_prod_next = w_prod_now + P_PROD_BITS'(i_rate);
    assign o_edge      = div100(w_prod_now) != div100(w_prod_next);

endmodule

// File: src/tdsdp_ctrl.sv
module tdsdp_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_vld,
    input  tdsdp_pkg::t_item                  i_item,
    input  logic [tdsdp_pkg::P_RATE_BITS-1:0] i_x_rate,
    input  logic [tdsdp_pkg::P_RATE_BITS-1:0] i_y_rate,
    input  logic                              i_out_ready,
    output logic                              o_take,
    output logic                              o_res_vld,
    output tdsdp_pkg::t_result                o_res
);
    import tdsdp_pkg::*;

    t_mode                   r_mode, n_mode;
    t_pos                    r_x_cnt, n_x_cnt;
    t_pos                    r_y_cnt, n_y_cnt;
    t_pos                    r_x_tgt, n_x_tgt;
    t_pos                    r_y_tgt, n_y_tgt;
    logic                    r_x_mov, n_x_mov;
    logic                    r_y_mov, n_y_mov;
    logic                    r_x_lvl, n_x_lvl;
    logic                    r_y_lvl, n_y_lvl;
    logic [P_PHASE_BITS-1:0] r_phase, n_phase;
    logic [7:0]              r_pins, n_pins;
    logic                    r_any, n_any;
    logic                    r_res_vld;
    t_result                 r_res, n_res;

    logic w_x_edge;
    logic w_y_edge;
    logic w_x_hit;
    logic w_y_hit;
    logic w_homed;

    tdsdp_rate u_x_rate (
        .i_rate  (i_x_rate),
        .i_phase (r_phase),
        .o_edge  (w_x_edge)
    );

    tdsdp_rate u_y_rate (
        .i_rate  (i_y_rate),
        .i_phase (r_phase),
        .o_edge  (w_y_edge)
    );

    assign o_take = i_item_vld && (!r_res_vld || i_out_ready);

    always_comb begin
        n_mode  = r_mode;
        n_x_cnt = r_x_cnt;
        n_y_cnt = r_y_cnt;
        n_x_tgt = r_x_tgt;
        n_y_tgt = r_y_tgt;
        n_x_mov = r_x_mov;
        n_y_mov = r_y_mov;
        n_x_lvl = r_x_lvl;
        n_y_lvl = r_y_lvl;
        n_phase = r_phase;
        n_pins  = r_pins;
        n_any   = r_any;
        w_x_hit = 1'b0;
        w_y_hit = 1'b0;
        w_homed = 1'b0;
        case (i_item.action)
            ACT_HOME: begin
                n_mode              = MODE_HOMING;
                n_x_mov             = 1'b1;
                n_y_mov             = 1'b1;
                n_pins[P_PIN_X_DIR] = 1'b0;
                n_pins[P_PIN_Y_DIR] = 1'b0;
            end
            ACT_MOVE: begin
                n_x_tgt = t_pos'(i_item.goal_x);
                n_y_tgt = t_pos'(i_item.goal_y);
                n_mode  = MODE_MOVE;
            end
            ACT_TICK: begin
                if (r_mode == MODE_HOMING && !r_x_mov && !r_y_mov) begin
                    n_x_cnt = '0;
                    n_y_cnt = '0;
                    w_homed = 1'b1;
                    n_mode  = MODE_MOVE;
                end else begin
                    if (r_mode == MODE_MOVE) begin
                        // aim each axis at its goal
                        if ($signed(r_x_cnt) < $signed(r_x_tgt)) begin
                            n_x_mov             = 1'b1;
                            n_pins[P_PIN_X_DIR] = 1'b1;
                        end else if ($signed(r_x_cnt) > $signed(r_x_tgt)) begin
                            n_x_mov             = 1'b1;
                            n_pins[P_PIN_X_DIR] = 1'b0;
                        end else begin
                            n_x_mov = 1'b0;
                        end
                        if ($signed(r_y_cnt) < $signed(r_y_tgt)) begin
                            n_y_mov             = 1'b1;
                            n_pins[P_PIN_Y_DIR] = 1'b1;
                        end else if ($signed(r_y_cnt) > $signed(r_y_tgt)) begin
                            n_y_mov             = 1'b1;
                            n_pins[P_PIN_Y_DIR] = 1'b0;
                        end else begin
                            n_y_mov = 1'b0;
                        end
                        if (!n_x_mov && !n_y_mov) begin
                            n_mode = MODE_IDLE;
                        end
                    end

                    w_x_hit = n_x_mov && !n_pins[P_PIN_X_DIR] && !i_item.x_switch_n;
                    w_y_hit = n_y_mov && !n_pins[P_PIN_Y_DIR] && !i_item.y_switch_n;
                    if (r_mode == MODE_HOMING) begin
                        if (w_x_hit) begin
                            n_x_mov = 1'b0;
                        end
                        if (w_y_hit) begin
                            n_y_mov = 1'b0;
                        end
                    end

                    // count on each step edge that drives the step pin low
                    if (n_x_mov && w_x_edge) begin
                        n_pins[P_PIN_X_STEP] = r_x_lvl;
                        n_x_lvl              = !r_x_lvl;
                        if (!r_x_lvl) begin
                            n_x_cnt = n_pins[P_PIN_X_DIR] ? r_x_cnt + t_pos'(1)
                                                          : r_x_cnt - t_pos'(1);
                        end
                    end
                    if (n_y_mov && w_y_edge) begin
                        n_pins[P_PIN_Y_STEP] = r_y_lvl;
                        n_y_lvl              = !r_y_lvl;
                        if (!r_y_lvl) begin
                            n_y_cnt = n_pins[P_PIN_Y_DIR] ? r_y_cnt + t_pos'(1)
                                                          : r_y_cnt - t_pos'(1);
                        end
                    end

                    n_any   = n_x_mov || n_y_mov;
                    n_phase = (r_phase >= P_PHASE_LAST) ? '0 : r_phase + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_res.port_pins     = n_pins;
        n_res.x_position    = P_OUT_BITS'(n_x_cnt);
        n_res.y_position    = P_OUT_BITS'(n_y_cnt);
        n_res.x_limit_hit   = w_x_hit;
        n_res.y_limit_hit   = w_y_hit;
        n_res.homed_pulse   = w_homed;
        n_res.motion_active = n_any;
        n_res.current_mode  = mode_code(n_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_x_cnt   <= '0;
            r_y_cnt   <= '0;
            r_x_tgt   <= '0;
            r_y_tgt   <= '0;
            r_x_mov   <= 1'b0;
            r_y_mov   <= 1'b0;
            r_x_lvl   <= 1'b0;
            r_y_lvl   <= 1'b0;
            r_phase   <= '0;
            r_pins    <= P_PINS_RESET;
            r_any     <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_mode    <= n_mode;
                r_x_cnt   <= n_x_cnt;
                r_y_cnt   <= n_y_cnt;
                r_x_tgt   <= n_x_tgt;
                r_y_tgt   <= n_y_tgt;
                r_x_mov   <= n_x_mov;
                r_y_mov   <= n_y_mov;
                r_x_lvl   <= n_x_lvl;
                r_y_lvl   <= n_y_lvl;
                r_phase   <= n_phase;
                r_pins    <= n_pins;
                r_any     <= n_any;
                r_res_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

endmodule
